// ----- rtl/shlp_pkg.sv -----
package shlp_pkg;

   localparam int unsigned HashW      = 64;
   localparam int unsigned CharW      = 8;
   localparam int unsigned CapW       = 5;
   localparam int unsigned SlotW      = 4;
   localparam int unsigned ModBits    = 4;
   localparam int unsigned ModSteps   = HashW / ModBits;
   localparam int unsigned ModCntW    = $clog2(ModSteps);
   localparam logic [CapW-1:0] CapReset = 5'd16;
   localparam logic [CharW-1:0] CaseOffset = 8'd32;
   localparam logic [CharW-1:0] UpperFirst = 8'd65;
   localparam logic [CharW-1:0] UpperLast  = 8'd90;

   typedef enum logic [4:0] {
      ST_CLEAR = 5'b00001,
      ST_IDLE  = 5'b00010,
      ST_MOD   = 5'b00100,
      ST_READ  = 5'b01000,
      ST_CHECK = 5'b10000
   } state_type;

   function automatic logic [CharW-1:0] fold_case(input logic [CharW-1:0] c);
      logic [CharW-1:0] r;
      r = c;
      if (c >= UpperFirst && c <= UpperLast) begin
         r = c + CaseOffset;
      end
      return r;
   endfunction

endpackage

// ----- rtl/shlp_if.sv -----
interface shlp_req_if;
   logic                          valid;
   logic                          ready;
   logic [shlp_pkg::CharW-1:0]    key_char;
   logic                          key_last;

   modport source (output valid, output key_char, output key_last, input ready);
   modport sink   (input valid, input key_char, input key_last, output ready);
endinterface

interface shlp_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [shlp_pkg::SlotW-1:0]    slot_index;
   logic                          table_full;
   logic [shlp_pkg::CapW-1:0]     entry_total;

   modport source (output valid, output slot_index, output table_full,
                   output entry_total, input ready);
   modport sink   (input valid, input slot_index, input table_full,
                   input entry_total, output ready);
endinterface

// ----- rtl/shlp_ram.sv -----
module shlp_ram #(
   parameter int unsigned WIDTH = 1,
   parameter int unsigned DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/string_hash_linear_probe_insert_top.sv -----
// Flow: a non-final character is folded into the hash while idle; the final one goes
// through hash reduction (4 dividend bits per cycle), then READ and CHECK per slot probed.
// Throughput: one character per cycle while a key streams in; one key at a time.
// Reset: synchronous; clears control state, then sweeps the slot-used RAM one entry
// per cycle before the first transaction is accepted.
module string_hash_linear_probe_insert_top #(
   parameter int unsigned TABLE_SLOTS = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   shlp_req_if.sink                    req_ch,
   shlp_rsp_if.source                  rsp_ch,
   input  logic                        csr_wr_en,
   input  logic [shlp_pkg::CapW-1:0]   csr_wr_data
);

   localparam int unsigned AddrW  = $clog2(TABLE_SLOTS);
   localparam int unsigned CapMax = (TABLE_SLOTS < 31) ? TABLE_SLOTS : 31;
   localparam logic [shlp_pkg::CapW-1:0] CapLimit = shlp_pkg::CapW'(CapMax);
   localparam logic [AddrW-1:0] LastAddr = AddrW'(TABLE_SLOTS - 1);

   shlp_pkg::state_type state_ff, state_in;

   logic [shlp_pkg::CapW-1:0]    csr_cap_ff, csr_cap_in;
   logic [shlp_pkg::HashW-1:0]   hash_ff, hash_in;
   logic [shlp_pkg::CapW-1:0]    cap_ff, cap_in;
   logic [shlp_pkg::CapW-1:0]    rem_ff, rem_in;
   logic [shlp_pkg::ModCntW-1:0] mod_cnt_ff, mod_cnt_in;
   logic [shlp_pkg::CapW-1:0]    pos_ff, pos_in;
   logic [shlp_pkg::CapW-1:0]    probe_cnt_ff, probe_cnt_in;
   logic [shlp_pkg::CapW-1:0]    count_ff, count_in;
   logic [AddrW-1:0]             clr_addr_ff, clr_addr_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic [shlp_pkg::SlotW-1:0]   rsp_slot_ff, rsp_slot_in;
   logic                         rsp_full_ff, rsp_full_in;
   logic [shlp_pkg::CapW-1:0]    rsp_total_ff, rsp_total_in;

   logic                         mem_wr_en;
   logic [AddrW-1:0]             mem_wr_addr;
   logic                         mem_rd_en;
   logic                         mem_rd_data;

   logic [shlp_pkg::CapW-1:0]    cap_eff;
   logic [shlp_pkg::CharW-1:0]   char_folded;
   logic [shlp_pkg::HashW-1:0]   hash_step;
   logic [shlp_pkg::CapW-1:0]    rem_step;
   logic [shlp_pkg::CapW-1:0]    pos_inc;
   logic [shlp_pkg::CapW-1:0]    pos_wrap;
   logic                         out_free;
   logic                         req_take;

   shlp_ram #(
      .WIDTH (1),
      .DEPTH (TABLE_SLOTS)
   ) u_used_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (state_ff != shlp_pkg::ST_CLEAR),
      .rd_en   (mem_rd_en),
      .rd_addr (AddrW'(pos_ff)),
      .rd_data (mem_rd_data)
   );

   always_comb begin
      if (csr_cap_ff == '0) begin
         cap_eff = shlp_pkg::CapW'(1);
      end else if (csr_cap_ff > CapLimit) begin
         cap_eff = CapLimit;
      end else begin
         cap_eff = csr_cap_ff;
      end
   end

   assign char_folded = shlp_pkg::fold_case(req_ch.key_char);
   // h*33 + c
   assign hash_step = (hash_ff << 5) + hash_ff + shlp_pkg::HashW'(char_folded);

   // remainder by the captured capacity, ModBits dividend bits per cycle
   always_comb begin
      logic [shlp_pkg::CapW:0]   tmp;
      logic [shlp_pkg::CapW-1:0] r;
      r = rem_ff;
      for (int i = 0; i < shlp_pkg::ModBits; i++) begin
         tmp = {r, hash_ff[shlp_pkg::HashW-1-i]};
         if (tmp >= {1'b0, cap_ff}) begin
            tmp = tmp - {1'b0, cap_ff};
         end
         r = tmp[shlp_pkg::CapW-1:0];
      end
      rem_step = r;
   end

   assign pos_inc  = pos_ff + shlp_pkg::CapW'(1);
   assign pos_wrap = (pos_inc == cap_ff) ? '0 : pos_inc;
   assign out_free = !rsp_valid_ff || rsp_ch.ready;
   assign req_take = req_ch.valid && (state_ff == shlp_pkg::ST_IDLE);

   always_comb begin
      state_in     = state_ff;
      csr_cap_in   = csr_wr_en ? csr_wr_data : csr_cap_ff;
      hash_in      = hash_ff;
      cap_in       = cap_ff;
      rem_in       = rem_ff;
      mod_cnt_in   = mod_cnt_ff;
      pos_in       = pos_ff;
      probe_cnt_in = probe_cnt_ff;
      count_in     = count_ff;
      clr_addr_in  = clr_addr_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_slot_in  = rsp_slot_ff;
      rsp_full_in  = rsp_full_ff;
      rsp_total_in = rsp_total_ff;
      mem_wr_en    = 1'b0;
      mem_wr_addr  = AddrW'(pos_ff);
      mem_rd_en    = 1'b0;

      unique case (state_ff)
         shlp_pkg::ST_CLEAR: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = clr_addr_ff;
            clr_addr_in = clr_addr_ff + AddrW'(1);
            if (clr_addr_ff == LastAddr) begin
               state_in = shlp_pkg::ST_IDLE;
            end
         end
         shlp_pkg::ST_IDLE: begin
            if (req_take) begin
               hash_in = hash_step;
               if (req_ch.key_last) begin
                  cap_in     = cap_eff;
                  rem_in     = '0;
                  mod_cnt_in = '0;
                  state_in   = shlp_pkg::ST_MOD;
               end
            end
         end
         shlp_pkg::ST_MOD: begin
            // shifting out the dividend leaves the accumulator cleared
            hash_in    = hash_ff << shlp_pkg::ModBits;
            rem_in     = rem_step;
            mod_cnt_in = mod_cnt_ff + shlp_pkg::ModCntW'(1);
            if (mod_cnt_ff == shlp_pkg::ModCntW'(shlp_pkg::ModSteps - 1)) begin
               pos_in       = rem_step;
               probe_cnt_in = '0;
               state_in     = shlp_pkg::ST_READ;
            end
         end
         shlp_pkg::ST_READ: begin
            mem_rd_en = 1'b1;
            state_in  = shlp_pkg::ST_CHECK;
         end
         shlp_pkg::ST_CHECK: begin
            if (!mem_rd_data) begin
               if (out_free) begin
                  mem_wr_en    = 1'b1;
                  count_in     = count_ff + shlp_pkg::CapW'(1);
                  rsp_valid_in = 1'b1;
                  rsp_slot_in  = pos_ff[shlp_pkg::SlotW-1:0];
                  rsp_full_in  = 1'b0;
                  rsp_total_in = count_ff + shlp_pkg::CapW'(1);
                  state_in     = shlp_pkg::ST_IDLE;
               end
            end else if (probe_cnt_ff + shlp_pkg::CapW'(1) == cap_ff) begin
               if (out_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_slot_in  = '0;
                  rsp_full_in  = 1'b1;
                  rsp_total_in = count_ff;
                  state_in     = shlp_pkg::ST_IDLE;
               end
            end else begin
               pos_in       = pos_wrap;
               probe_cnt_in = probe_cnt_ff + shlp_pkg::CapW'(1);
               state_in     = shlp_pkg::ST_READ;
            end
         end
         default: begin
            state_in = shlp_pkg::ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= shlp_pkg::ST_CLEAR;
         csr_cap_ff   <= shlp_pkg::CapReset;
         hash_ff      <= '0;
         count_ff     <= '0;
         clr_addr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         csr_cap_ff   <= csr_cap_in;
         hash_ff      <= hash_in;
         count_ff     <= count_in;
         clr_addr_ff  <= clr_addr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cap_ff       <= cap_in;
      rem_ff       <= rem_in;
      mod_cnt_ff   <= mod_cnt_in;
      pos_ff       <= pos_in;
      probe_cnt_ff <= probe_cnt_in;
      rsp_slot_ff  <= rsp_slot_in;
      rsp_full_ff  <= rsp_full_in;
      rsp_total_ff <= rsp_total_in;
   end

   assign req_ch.ready       = (state_ff == shlp_pkg::ST_IDLE);
   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.slot_index  = rsp_slot_ff;
   assign rsp_ch.table_full  = rsp_full_ff;
   assign rsp_ch.entry_total = rsp_total_ff;

endmodule
